// ----- rtl/etpd_pkg.sv -----
// shared types and constants for the tiled polarity plane decoder
// no dependencies; imported by every module in rtl/
package etpd_pkg;

  localparam int TILE_ROWS         = 16;
  localparam int TILE_HEADER_BYTES = 18;
  localparam int TILE_PAD_BYTES    = 14;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_CODE       = 3'd0,
    REG_DOWN_CODE     = 3'd1,
    REG_IDLE_CODE     = 3'd2,
    REG_FRAME_ROWS    = 3'd3,
    REG_FRAME_COLS    = 3'd4,
    REG_SENSOR_WIDTH  = 3'd5,
    REG_SENSOR_HEIGHT = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PLANE  = 2'd1,
    PH_PAD    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0]  up_code;
    logic [1:0]  down_code;
    logic [1:0]  idle_code;
    logic [15:0] frame_rows;
    logic [15:0] frame_cols;
    logic [15:0] sensor_width;
    logic [15:0] sensor_height;
  } cfg_t;

  // one plane byte that produces at least one event
  typedef struct packed {
    logic [39:0] time_us;
    logic [15:0] y;
    logic [13:0] byte_in_row;
    logic [3:0]  pol;
    logic [3:0]  mask;
  } ev_entry_t;

endpackage

// ----- rtl/etpd_front.sv -----
// front end: tracks the position inside the tiled frame and classifies pixels
// depends on etpd_pkg; feeds etpd_queue with bytes that carry events
module etpd_front
  import etpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  payload_byte,
  input  logic        frame_start,
  input  logic [39:0] frame_time_us,
  output logic        push,
  output ev_entry_t   push_data,
  input  logic        queue_ready
);

  logic        in_frame_r, in_frame_nxt;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [3:0]  row_r, row_nxt;
  logic [13:0] bir_r, bir_nxt;
  logic [11:0] tile_r, tile_nxt;

  // position after a possible frame restart
  logic        in_frame_e;
  phase_t      phase_e;
  logic [4:0]  count_e;
  logic [3:0]  row_e;
  logic [13:0] bir_e;
  logic [11:0] tile_e;

  logic        accept;
  logic [4:0]  count_inc;
  logic [14:0] bir_inc;
  logic [12:0] tile_inc;
  logic [15:0] y_e;
  logic [3:0]  mask;
  logic [3:0]  pol;

  assign byte_ready = queue_ready;
  assign accept     = byte_valid && queue_ready;

  always_comb begin
    if (frame_start) begin
      in_frame_e = 1'b1;
      phase_e    = PH_HEADER;
      count_e    = '0;
      row_e      = '0;
      bir_e      = '0;
      tile_e     = '0;
    end else begin
      in_frame_e = in_frame_r;
      phase_e    = phase_r;
      count_e    = count_r;
      row_e      = row_r;
      bir_e      = bir_r;
      tile_e     = tile_r;
    end
  end

  assign count_inc = count_e + 5'd1;
  assign bir_inc   = {1'b0, bir_e} + 15'd1;
  assign tile_inc  = {1'b0, tile_e} + 13'd1;
  assign y_e       = {tile_e, row_e};

  // per-pixel classification: idle first, then up, then down
  always_comb begin
    logic [1:0]  v;
    logic [15:0] x;
    for (int q = 0; q < 4; q++) begin
      v = payload_byte[2*q +: 2];
      x = {bir_e, 2'(q)};
      pol[q]  = (v == cfg.up_code);
      mask[q] = (v != cfg.idle_code) && ((v == cfg.up_code) || (v == cfg.down_code)) &&
                (x < cfg.sensor_width) && (y_e < cfg.sensor_height);
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    row_nxt      = row_r;
    bir_nxt      = bir_r;
    tile_nxt     = tile_r;
    if (accept) begin
      in_frame_nxt = in_frame_e;
      phase_nxt    = phase_e;
      count_nxt    = count_e;
      row_nxt      = row_e;
      bir_nxt      = bir_e;
      tile_nxt     = tile_e;
      if (in_frame_e) begin
        unique case (phase_e)
          PH_HEADER: begin
            count_nxt = count_inc;
            if (count_inc >= 5'(TILE_HEADER_BYTES)) begin
              phase_nxt = PH_PLANE;
              count_nxt = '0;
              row_nxt   = '0;
              bir_nxt   = '0;
            end
          end
          PH_PLANE: begin
            bir_nxt = bir_inc[13:0];
            if (bir_inc >= {1'b0, cfg.frame_cols[15:2]}) begin
              bir_nxt = '0;
              row_nxt = row_e + 4'd1;
              if (row_e == 4'(TILE_ROWS - 1)) begin
                row_nxt   = '0;
                phase_nxt = PH_PAD;
                count_nxt = '0;
              end
            end
          end
          default: begin
            count_nxt = count_inc;
            if (count_inc >= 5'(TILE_PAD_BYTES)) begin
              if (tile_inc >= {1'b0, cfg.frame_rows[15:4]}) begin
                in_frame_nxt = 1'b0;
                tile_nxt     = '0;
              end else begin
                tile_nxt = tile_inc[11:0];
              end
              phase_nxt = PH_HEADER;
              count_nxt = '0;
              row_nxt   = '0;
              bir_nxt   = '0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      phase_r    <= PH_HEADER;
      count_r    <= '0;
      row_r      <= '0;
      bir_r      <= '0;
      tile_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      row_r      <= row_nxt;
      bir_r      <= bir_nxt;
      tile_r     <= tile_nxt;
    end
  end

  assign push = accept && in_frame_e && (phase_e == PH_PLANE) && (mask != 4'd0);

  always_comb begin
    push_data.time_us     = frame_time_us;
    push_data.y           = y_e;
    push_data.byte_in_row = bir_e;
    push_data.pol         = pol;
    push_data.mask        = mask;
  end

endmodule

// ----- rtl/etpd_queue.sv -----
// short queue between the front end and the event emitter
// depends on etpd_pkg for the entry type and depth
module etpd_queue
  import etpd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ev_entry_t push_data,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output ev_entry_t pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  ev_entry_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]     cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/etpd_back.sv -----
// back end: expands one queued byte into its events, one per cycle while the output is not stalled
// depends on etpd_pkg; drives the registered result stream
module etpd_back
  import etpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  ev_entry_t   q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic        out_pol,
  output logic [39:0] out_time,
  output logic        out_last
);

  logic        cur_valid_r, cur_valid_nxt;
  ev_entry_t   cur_r;
  logic [3:0]  mask_r;
  logic [3:0]  mask_left;
  logic [1:0]  sel;
  logic        out_free, issue, done, take;

  logic        ov_r;
  logic [15:0] ox_r, oy_r;
  logic        opol_r, olast_r;
  logic [39:0] otime_r;

  // lowest remaining pixel goes first
  always_comb begin
    priority if (mask_r[0]) sel = 2'd0;
    else if (mask_r[1])     sel = 2'd1;
    else if (mask_r[2])     sel = 2'd2;
    else                    sel = 2'd3;
  end

  assign mask_left = mask_r & ~(4'd1 << sel);
  assign out_free  = !ov_r || out_ready;
  assign issue     = cur_valid_r && out_free;
  assign done      = issue && (mask_left == 4'd0);
  assign take      = q_valid && (!cur_valid_r || done);
  assign q_pop     = take;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    if (take) begin
      cur_valid_nxt = 1'b1;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      if (issue) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r  <= q_data;
      mask_r <= q_data.mask;
    end else if (issue) begin
      mask_r <= mask_left;
    end
    if (issue) begin
      ox_r    <= {cur_r.byte_in_row, sel};
      oy_r    <= cur_r.y;
      opol_r  <= cur_r.pol[sel];
      otime_r <= cur_r.time_us;
      olast_r <= (mask_left == 4'd0);
    end
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_pol   = opol_r;
  assign out_time  = otime_r;
  assign out_last  = olast_r;

endmodule

// ----- rtl/evs_tiled_polarity_plane_decoder.sv -----
// Decodes a tiled 2-bit polarity plane, one payload byte per transfer, into
// single pixel events. A byte with in_tuser set opens a frame; each tile is
// 18 header bytes, 16 rows of frame_cols/4 plane bytes and 14 pad bytes.
// A plane byte with n events yields n events, one at a time through the
// one-event output register of the emitter. A two-entry queue sits between
// the position tracker and the emitter, so input keeps flowing while results
// wait, as long as the queue has room. Registers may be written only while idle.
module evs_tiled_polarity_plane_decoder
  import etpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // payload_byte[7:0], frame_time_us[47:8]
  input  logic                  in_tuser,   // frame_start
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,  // event_x[15:0], event_y[31:16], event_time[71:32]
  output logic                  out_tuser,  // event_polarity
  output logic                  out_tlast,  // last_of_byte
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg_r;
  logic        push, queue_ready, q_valid, q_pop;
  ev_entry_t   push_data, q_data;
  logic [15:0] ev_x, ev_y;
  logic [39:0] ev_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_code       <= 2'd1;
      cfg_r.down_code     <= 2'd2;
      cfg_r.idle_code     <= 2'd0;
      cfg_r.frame_rows    <= 16'd16;
      cfg_r.frame_cols    <= 16'd4;
      cfg_r.sensor_width  <= 16'hFFFF;
      cfg_r.sensor_height <= 16'hFFFF;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_UP_CODE:       cfg_r.up_code       <= cfg_data[1:0];
        REG_DOWN_CODE:     cfg_r.down_code     <= cfg_data[1:0];
        REG_IDLE_CODE:     cfg_r.idle_code     <= cfg_data[1:0];
        REG_FRAME_ROWS:    cfg_r.frame_rows    <= cfg_data;
        REG_FRAME_COLS:    cfg_r.frame_cols    <= cfg_data;
        REG_SENSOR_WIDTH:  cfg_r.sensor_width  <= cfg_data;
        REG_SENSOR_HEIGHT: cfg_r.sensor_height <= cfg_data;
        default: ;
      endcase
    end
  end

  etpd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .byte_valid    (in_tvalid),
    .byte_ready    (in_tready),
    .payload_byte  (in_tdata[7:0]),
    .frame_start   (in_tuser),
    .frame_time_us (in_tdata[47:8]),
    .push          (push),
    .push_data     (push_data),
    .queue_ready   (queue_ready)
  );

  etpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (queue_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  etpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (ev_x),
    .out_y     (ev_y),
    .out_pol   (out_tuser),
    .out_time  (ev_time),
    .out_last  (out_tlast)
  );

  assign out_tdata = {ev_time, ev_y, ev_x};

endmodule
